// ----- sv/sia_pkg.sv -----
package sia_pkg;

    localparam int DEPTH_DEF       = 256;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int OPCODE_W = 2;
    localparam int ITEM_W   = 32;
    localparam int POS_W    = 8;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;

    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;

    localparam logic [COUNT_W-1:0] CAP_RESET = 9'd256;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [ITEM_W-1:0]   item_value;
        logic [POS_W-1:0]    position;
    } cmd_t;

    typedef struct packed {
        logic [ITEM_W-1:0]   read_value;
        logic [COUNT_W-1:0]  entry_count;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    // strobes and shared operands broadcast to every cell
    typedef struct packed {
        logic               ins;
        logic               rem;
        logic               rd_load;
        logic               rd_shift;
        logic [POS_W-1:0]   pos;
        logic [COUNT_W-1:0] count;
    } cell_ctl_t;

    typedef enum logic {
        S_IDLE,
        S_SHIFT
    } state_t;

endpackage

// ----- sv/sia_cell.sv -----
module sia_cell #(
    parameter int VALUE_WIDTH = sia_pkg::VALUE_WIDTH_DEF,
    parameter int INDEX       = 0
) (
    input  logic                   clk,
    input  sia_pkg::cell_ctl_t     ctl,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic [VALUE_WIDTH-1:0] prev_entry,
    input  logic                   prev_lt,
    input  logic [VALUE_WIDTH-1:0] next_entry,
    input  logic [VALUE_WIDTH-1:0] next_rd,
    output logic [VALUE_WIDTH-1:0] entry,
    output logic                   lt,
    output logic [VALUE_WIDTH-1:0] rd
);

    logic [VALUE_WIDTH-1:0] entry_reg;
    logic [VALUE_WIDTH-1:0] entry_next;
    logic [VALUE_WIDTH-1:0] rd_reg;
    logic [VALUE_WIDTH-1:0] rd_next;
    logic                   occupied;

    assign occupied = 32'(ctl.count) > INDEX;
    assign lt       = occupied && (entry_reg < value);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ins && !lt)
        begin
            // first cell not below the new value takes it, the rest move up
            entry_next = prev_lt ? value : prev_entry;
        end
        else if (ctl.rem && (32'(ctl.pos) <= INDEX))
        begin
            entry_next = next_entry;
        end
    end

    always_comb
    begin
        rd_next = rd_reg;
        if (ctl.rd_load)
        begin
            rd_next = entry_reg;
        end
        else if (ctl.rd_shift)
        begin
            rd_next = next_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        rd_reg    <= rd_next;
    end

    assign entry = entry_reg;
    assign rd    = rd_reg;

endmodule

// ----- sv/sorted_insert_array.sv -----
// Sorted store of up to DEPTH unsigned values held in a row of cells, one entry per cell.
// A command is taken when start is high and busy is low; its result is on rsp for exactly
// one cycle with done high and cannot be held off. Insert, remove, refused commands and the
// unused opcode give their result in the cycle after acceptance and a new command can be
// taken in that same cycle, so these run at one per cycle: every cell compares and moves
// its entry in parallel. A lookup at index k copies the row into a readout chain that walks
// one cell per cycle toward cell 0; busy stays high until entry k has reached cell 0, and
// the result is registered from cell 0 once it is there. No clearing pass is needed after reset.
module sorted_insert_array #(
    parameter int DEPTH       = sia_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = sia_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  sia_pkg::cmd_t                 cmd,
    output logic                          done,
    output sia_pkg::rsp_t                 rsp,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sia_pkg::COUNT_W-1:0]   cfg_data
);

    sia_pkg::state_t                state_reg;
    sia_pkg::state_t                state_next;
    logic [sia_pkg::COUNT_W-1:0]    count_reg;
    logic [sia_pkg::COUNT_W-1:0]    count_next;
    logic [sia_pkg::COUNT_W-1:0]    cap_reg;
    logic [sia_pkg::POS_W-1:0]      cnt_reg;
    logic [sia_pkg::POS_W-1:0]      cnt_next;
    logic                           done_reg;
    logic                           done_next;
    sia_pkg::rsp_t                  rsp_reg;
    sia_pkg::rsp_t                  rsp_next;
    sia_pkg::cell_ctl_t             ctl;

    logic                           accept;
    logic                           full;
    logic                           idx_ok;
    logic [VALUE_WIDTH-1:0]         value;

    logic [VALUE_WIDTH-1:0]         entry_w [DEPTH];
    logic                           lt_w    [DEPTH];
    logic [VALUE_WIDTH-1:0]         rd_w    [DEPTH];

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg == sia_pkg::S_SHIFT);
    assign accept    = start && !busy;
    assign full      = (32'(count_reg) >= DEPTH) || (count_reg >= cap_reg);
    assign idx_ok    = sia_pkg::COUNT_W'(cmd.position) < count_reg;
    assign value     = VALUE_WIDTH'(cmd.item_value);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sia_pkg::S_IDLE:
            begin
                if (accept && (cmd.opcode == sia_pkg::OP_LOOKUP) && idx_ok)
                begin
                    state_next = sia_pkg::S_SHIFT;
                end
            end
            sia_pkg::S_SHIFT:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = sia_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sia_pkg::S_IDLE;
            end
        endcase
    end

    // outputs, cell strobes and counters
    always_comb
    begin
        ctl          = '0;
        ctl.pos      = cmd.position;
        ctl.count    = count_reg;
        count_next   = count_reg;
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        rsp_next     = '0;
        case (state_reg)
            sia_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    done_next = 1'b1;
                    case (cmd.opcode)
                        sia_pkg::OP_INSERT:
                        begin
                            if (full)
                            begin
                                rsp_next.status = sia_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctl.ins    = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        sia_pkg::OP_LOOKUP:
                        begin
                            if (!idx_ok)
                            begin
                                rsp_next.status = sia_pkg::ST_BAD_INDEX;
                            end
                            else
                            begin
                                ctl.rd_load = 1'b1;
                                cnt_next    = cmd.position;
                                done_next   = 1'b0;
                            end
                        end
                        sia_pkg::OP_REMOVE:
                        begin
                            if (!idx_ok)
                            begin
                                rsp_next.status = sia_pkg::ST_BAD_INDEX;
                            end
                            else
                            begin
                                ctl.rem    = 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            rsp_next.status = sia_pkg::ST_OK;
                        end
                    endcase
                end
            end
            sia_pkg::S_SHIFT:
            begin
                if (cnt_reg == '0)
                begin
                    done_next           = 1'b1;
                    rsp_next.read_value = sia_pkg::ITEM_W'(rd_w[0]);
                end
                else
                begin
                    ctl.rd_shift = 1'b1;
                    cnt_next     = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
        rsp_next.entry_count = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sia_pkg::S_IDLE;
            count_reg <= '0;
            cap_reg   <= sia_pkg::CAP_RESET;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [VALUE_WIDTH-1:0] prev_entry;
        logic                   prev_lt;
        logic [VALUE_WIDTH-1:0] next_entry;
        logic [VALUE_WIDTH-1:0] next_rd;

        if (i == 0)
        begin : g_first
            assign prev_entry = value;
            assign prev_lt    = 1'b1;
        end
        else
        begin : g_mid
            assign prev_entry = entry_w[i-1];
            assign prev_lt    = lt_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign next_entry = entry_w[i];
            assign next_rd    = '0;
        end
        else
        begin : g_inner
            assign next_entry = entry_w[i+1];
            assign next_rd    = rd_w[i+1];
        end

        sia_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .INDEX       (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .value      (value),
            .prev_entry (prev_entry),
            .prev_lt    (prev_lt),
            .next_entry (next_entry),
            .next_rd    (next_rd),
            .entry      (entry_w[i]),
            .lt         (lt_w[i]),
            .rd         (rd_w[i])
        );
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= DEPTH)
        else $error("entry count beyond built depth");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ins |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the count");

    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rem |=> count_reg == $past(count_reg) - 1'b1)
        else $error("remove did not shrink the count");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.status != sia_pkg::ST_OK) |-> rsp.read_value == '0)
        else $error("refused command returned data");

    a_shift_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rd_shift |=> !done)
        else $error("lookup result before readout reached cell 0");

endmodule

// ----- sim/sia_checker.sv -----
`timescale 1ns / 1ps

module sia_checker
    import sia_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  cmd_t               cmd,
    input  logic               done,
    input  rsp_t               rsp,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data,
    output int                 fail_count,
    output int                 outstanding,
    output int                 shadow_level,
    output int                 results_checked,
    output int                 refused_inserts,
    output int                 peak_level
);

    logic [ITEM_W-1:0]  shadow_list [0:DEPTH_DEF-1];
    logic [COUNT_W-1:0] shadow_count;
    logic [COUNT_W-1:0] capacity;
    rsp_t               predicted_q [$];

    task automatic report(input string msg);
        $display("%0t sia_checker: %s", $time, msg);
        fail_count++;
    endtask

    // applies one request to the shadow list and works out its answer
    task automatic apply_request(input cmd_t c, output rsp_t r);
        int                 at;
        int                 j;
        logic [COUNT_W-1:0] room;
        r = '0;
        room = (capacity > DEPTH_DEF) ? COUNT_W'(DEPTH_DEF) : capacity;
        case (c.opcode)
            OP_INSERT:
            begin
                if (shadow_count >= room)
                begin
                    r.status = ST_FULL;
                    refused_inserts++;
                end
                else
                begin
                    // new value goes ahead of older equal values
                    at = 0;
                    while (at < shadow_count && shadow_list[at] < c.item_value)
                        at++;
                    for (j = shadow_count; j > at; j--)
                        shadow_list[j] = shadow_list[j-1];
                    shadow_list[at] = c.item_value;
                    shadow_count++;
                end
            end
            OP_LOOKUP:
            begin
                if (c.position >= shadow_count)
                    r.status = ST_BAD_INDEX;
                else
                    r.read_value = shadow_list[c.position];
            end
            OP_REMOVE:
            begin
                if (c.position >= shadow_count)
                    r.status = ST_BAD_INDEX;
                else
                begin
                    for (j = c.position; j + 1 < shadow_count; j++)
                        shadow_list[j] = shadow_list[j+1];
                    shadow_count--;
                end
            end
            default:
                ;
        endcase
        r.entry_count = shadow_count;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        rsp_t got;
        if (!rst_n)
        begin
            shadow_count = '0;
            capacity = CAP_RESET;
            predicted_q.delete();
            fail_count = 0;
            results_checked = 0;
            refused_inserts = 0;
            peak_level = 0;
            outstanding <= 0;
            shadow_level <= 0;
        end
        else
        begin
            if (done)
            begin
                results_checked++;
                if (predicted_q.size() == 0)
                    report($sformatf("result beat with nothing pending: value 0x%0h count %0d",
                                     rsp.read_value, rsp.entry_count));
                else
                begin
                    want = predicted_q.pop_front();
                    got = rsp;
                    if (got.read_value !== want.read_value)
                        report($sformatf("read_value expected 0x%0h got 0x%0h",
                                         want.read_value, got.read_value));
                    if (got.entry_count !== want.entry_count)
                        report($sformatf("entry_count expected %0d got %0d",
                                         want.entry_count, got.entry_count));
                    if (got.status !== want.status)
                        report($sformatf("status expected %0d got %0d",
                                         want.status, got.status));
                end
            end
            // a request taken at this edge still sees the old limit
            if (start && !busy)
            begin
                apply_request(cmd, want);
                predicted_q.push_back(want);
                if (shadow_count > peak_level)
                    peak_level = shadow_count;
            end
            if (cfg_valid && cfg_ready)
                capacity = cfg_data;
            outstanding <= predicted_q.size();
            shadow_level <= shadow_count;
        end
    end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import sia_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 3000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    cmd_t               cmd = '0;
    logic               done;
    rsp_t               rsp;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data = '0;

    int fail_count;
    int outstanding;
    int shadow_level;
    int results_checked;
    int refused_inserts;
    int peak_level;
    int requests_sent = 0;
    int quiet_run = 0;
    int stall_cycles = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    sorted_insert_array uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    sia_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .cmd             (cmd),
        .done            (done),
        .rsp             (rsp),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .shadow_level    (shadow_level),
        .results_checked (results_checked),
        .refused_inserts (refused_inserts),
        .peak_level      (peak_level)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("no beat for %0d cycles", STALL_LIMIT);
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    // holds one request until it is taken, then maybe leaves a gap
    task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [ITEM_W-1:0] val,
                                input logic [POS_W-1:0] pos);
        int gap;
        int r;
        start <= 1'b1;
        cmd <= '{opcode: op, item_value: val, position: pos};
        do
            @(posedge clk);
        while (busy);
        requests_sent++;
        r = $urandom_range(0, 99);
        if (quiet_run > 0)
        begin
            quiet_run--;
            gap = 0;
        end
        else if (r < 5)
        begin
            quiet_run = $urandom_range(20, 40);
            gap = 0;
        end
        else if (r < 60)
            gap = 0;
        else if (r < 95)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_capacity(input int cap);
        cfg_valid <= 1'b1;
        cfg_data <= COUNT_W'(cap);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [ITEM_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return ITEM_W'($urandom_range(0, 15));
            default: return ITEM_W'($urandom);
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        if (shadow_level != 0 && $urandom_range(0, 3) != 0)
            return POS_W'($urandom_range(0, shadow_level - 1));
        return POS_W'($urandom_range(0, 255));
    endfunction

    task automatic run_phase(input int cap, input int n_items, input int ins_pct,
                             input int rem_pct);
        int               i;
        int               r;
        logic [OPCODE_W-1:0] op;
        drain();
        program_capacity(cap);
        for (i = 0; i < n_items; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < ins_pct)
                op = OP_INSERT;
            else if (r < ins_pct + rem_pct)
                op = OP_REMOVE;
            else if (r < 99)
                op = OP_LOOKUP;
            else
                op = OP_UNUSED;
            send_request(op, pick_value(), pick_position());
            if ($urandom_range(0, 49) == 0)
                drain();
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tiny store: empty reads, full refusal, extremes, equal values
        program_capacity(3);
        send_request(OP_LOOKUP, 32'h0, 8'd0);
        send_request(OP_REMOVE, 32'h0, 8'd255);
        send_request(OP_UNUSED, 32'h1234_5678, 8'd7);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 8'd0);
        send_request(OP_INSERT, 32'h0, 8'd0);
        send_request(OP_INSERT, 32'h7FFF_FFFF, 8'hFF);
        send_request(OP_INSERT, 32'h5, 8'd0);
        send_request(OP_LOOKUP, 32'hFFFF_FFFF, 8'd0);
        send_request(OP_LOOKUP, 32'h0, 8'd1);
        send_request(OP_LOOKUP, 32'h0, 8'd2);
        send_request(OP_LOOKUP, 32'h0, 8'd3);
        send_request(OP_REMOVE, 32'h0, 8'd1);
        send_request(OP_INSERT, 32'h0, 8'd0);
        send_request(OP_LOOKUP, 32'h0, 8'd1);
        send_request(OP_REMOVE, 32'h0, 8'd2);
        send_request(OP_REMOVE, 32'h0, 8'd2);

        // limit lowered under the count: entries stay, inserts refused until removes bring the count under it
        drain();
        program_capacity(1);
        send_request(OP_INSERT, 32'h9, 8'd0);
        send_request(OP_LOOKUP, 32'h0, 8'd1);
        send_request(OP_REMOVE, 32'h0, 8'd0);
        send_request(OP_INSERT, 32'h9, 8'd0);
        send_request(OP_REMOVE, 32'h0, 8'd0);
        send_request(OP_INSERT, 32'hAAAA_5555, 8'h80);

        // zero limit refuses every insert
        drain();
        program_capacity(0);
        send_request(OP_INSERT, 32'h5555_AAAA, 8'd0);
        send_request(OP_LOOKUP, 32'h0, 8'd0);
        send_request(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF);

        // fill to the full depth, then work a crowded store under lower limits
        run_phase(256, 290, 97, 1);
        run_phase(16, 60, 30, 50);
        run_phase($urandom_range(2, 255), 60, 45, 35);
        run_phase(1, 40, 40, 40);

        drain();
        $display("requests sent %0d, results checked %0d, refused inserts %0d",
                 requests_sent, results_checked, refused_inserts);
        $display("peak entry count %0d, limits 0, 1, 3, 16, 256 and one random", peak_level);
        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
